/* src/chunk_coverage_tracker_defines.svh */
// Assertion macros for the chunk coverage tracker.
`ifndef CHUNK_COVERAGE_TRACKER_DEFINES_SVH
`define CHUNK_COVERAGE_TRACKER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define CCT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the cycle after an antecedent.
`define CCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cct_pkg.sv */
package cct_pkg;

    localparam int CHUNK_BYTES_DEF = 90;
    localparam int MAX_SLOTS_DEF   = 1024;

    localparam int OFFSET_W  = 32;
    localparam int SIZE_W    = 17;
    localparam int FP_W      = 32;
    localparam int FILLED_W  = 11;
    localparam int COUNT_W   = 32;
    localparam int BYTES_W   = 8;
    localparam int REM_W     = 8;
    localparam int DIV_CNT_W = 2;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(2);

    localparam logic [FP_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [FP_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    function automatic logic [FP_W-1:0] crc_byte(input logic [FP_W-1:0] crc,
                                                 input logic [7:0] b);
        logic [FP_W-1:0] c;
        c = crc ^ {24'b0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* src/cct_ram.sv */
module cct_ram #(
    parameter int WIDTH  = 33,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/chunk_coverage_tracker.sv */
// Chunk coverage tracker: bytes of a record arrive one per transaction; a CRC-32 over the
// first CHUNK_BYTES bytes, zero-padded at the end of the record, fingerprints the chunk at
// the record offset, and one result transaction follows each last byte. Bytes that are not
// last are taken one per cycle. After a last byte the finish sequencer pads the CRC one zero
// byte per cycle while one multiplier turns the offset into a slot index by its reciprocal
// and a second then gives the remainder; the sequencer then passes through the slot memory
// read, the slot check and the coverage evaluation, and the result then waits for the
// downstream side; no byte is taken until it is delivered. After reset and after each
// write of the file size a clearing pass wipes every slot of the slot memory, during which
// no byte is taken.
`include "chunk_coverage_tracker_defines.svh"

module chunk_coverage_tracker
    import cct_pkg::*;
#(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int MAX_SLOTS   = MAX_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [SIZE_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OFFSET_W-1:0] record_offset,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic                check_overlap,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                accepted,
    output logic                all_received,
    output logic [FILLED_W-1:0] slots_filled,
    output logic [COUNT_W-1:0]  conflict_count
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int PROD_W = (CNT_W + BYTES_W > SIZE_W) ? CNT_W + BYTES_W : SIZE_W;
    localparam int RAM_W  = FP_W + 1;

    localparam int RECIP_SHIFT = SIZE_W + BYTES_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int MUL_W       = RECIP_SHIFT + SIZE_W;
    localparam int BACK_W      = SIZE_W + BYTES_W;

    localparam logic [BYTES_W-1:0] CHUNK_LEN = BYTES_W'(CHUNK_BYTES);
    localparam logic [RECIP_W-1:0] RECIP     =
        RECIP_W'((2 ** RECIP_SHIFT + CHUNK_BYTES - 1) / CHUNK_BYTES);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);
    localparam logic [CNT_W-1:0]   SLOT_CAP  = CNT_W'(MAX_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FINISH,
        S_READ,
        S_CHECK,
        S_EVAL,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [SIZE_W-1:0]      total_reg, total_next;
    logic                   clear_active_reg, clear_active_next;
    logic [SLOT_W-1:0]      clear_addr_reg, clear_addr_next;
    logic [FP_W-1:0]        crc_reg, crc_next;
    logic [BYTES_W-1:0]     bytes_seen_reg, bytes_seen_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;
    logic [OFFSET_W-1:0]    dq_reg, dq_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   check_reg, check_next;
    logic                   in_range_reg, in_range_next;
    logic [FP_W-1:0]        fp_reg, fp_next;
    logic [CNT_W-1:0]       filled_reg, filled_next;
    logic [COUNT_W-1:0]     conflicts_reg, conflicts_next;
    logic                   acc_reg, acc_next;
    logic                   accepted_reg, accepted_next;
    logic                   all_received_reg, all_received_next;
    logic [FILLED_W-1:0]    slots_filled_reg, slots_filled_next;
    logic [COUNT_W-1:0]     conflict_count_reg, conflict_count_next;

    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    logic [RAM_W-1:0]       ram_wdata;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [RAM_W-1:0]       ram_rdata;

    logic [MUL_W-1:0]       recip_prod;
    logic [SIZE_W-1:0]      quot;
    logic [BACK_W-1:0]      back_prod;
    logic [BACK_W-1:0]      rem_wide;
    logic [FP_W-1:0]        crc_final;
    logic [PROD_W-1:0]      cover_prod;

    assign in_stall  = !((state_reg == S_IDLE) && !clear_active_reg);
    assign out_valid = (state_reg == S_OUT);

    assign accepted       = accepted_reg;
    assign all_received   = all_received_reg;
    assign slots_filled   = slots_filled_reg;
    assign conflict_count = conflict_count_reg;

    assign recip_prod = MUL_W'(offset_reg[SIZE_W-1:0]) * MUL_W'(RECIP);
    assign quot       = recip_prod[MUL_W-1 -: SIZE_W];
    assign back_prod  = BACK_W'(dq_reg[SIZE_W-1:0]) * BACK_W'(CHUNK_LEN);
    assign rem_wide   = BACK_W'(offset_reg[SIZE_W-1:0]) - back_prod;
    assign crc_final  = ~crc_reg;
    assign cover_prod = PROD_W'(filled_reg) * PROD_W'(CHUNK_BYTES);
    assign ram_raddr  = dq_reg[SLOT_W-1:0];

    always_comb
    begin
        logic [COUNT_W-1:0] conf_after;

        state_next          = state_reg;
        total_next          = total_reg;
        clear_active_next   = clear_active_reg;
        clear_addr_next     = clear_addr_reg;
        crc_next            = crc_reg;
        bytes_seen_next     = bytes_seen_reg;
        offset_next         = offset_reg;
        dq_next             = dq_reg;
        rem_next            = rem_reg;
        div_cnt_next        = div_cnt_reg;
        check_next          = check_reg;
        in_range_next       = in_range_reg;
        fp_next             = fp_reg;
        filled_next         = filled_reg;
        conflicts_next      = conflicts_reg;
        acc_next            = acc_reg;
        accepted_next       = accepted_reg;
        all_received_next   = all_received_reg;
        slots_filled_next   = slots_filled_reg;
        conflict_count_next = conflict_count_reg;
        conf_after          = conflicts_reg;

        ram_we    = 1'b0;
        ram_waddr = ram_raddr;
        ram_wdata = {1'b1, fp_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    if (bytes_seen_reg < CHUNK_LEN)
                    begin
                        crc_next        = crc_byte(crc_reg, data_byte);
                        bytes_seen_next = bytes_seen_reg + 1'b1;
                    end
                    if (last_byte)
                    begin
                        offset_next  = record_offset;
                        dq_next      = record_offset;
                        rem_next     = '0;
                        div_cnt_next = '0;
                        check_next   = check_overlap;
                        state_next   = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (bytes_seen_reg < CHUNK_LEN)
                begin
                    crc_next        = crc_byte(crc_reg, 8'h00);
                    bytes_seen_next = bytes_seen_reg + 1'b1;
                end
                if (div_cnt_reg == '0)
                begin
                    dq_next      = OFFSET_W'(quot);
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
                else if (div_cnt_reg < DIV_STEPS)
                begin
                    rem_next     = REM_W'(rem_wide);
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
                else if (bytes_seen_reg >= CHUNK_LEN)
                begin
                    fp_next         = (crc_final == '0) ? FP_W'(1) : crc_final;
                    crc_next        = CRC_INIT;
                    bytes_seen_next = '0;
                    in_range_next   = (rem_reg == '0)
                                   && (dq_reg < OFFSET_W'(MAX_SLOTS))
                                   && (offset_reg < OFFSET_W'(total_reg));
                    state_next      = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (in_range_reg)
                begin
                    if (!ram_rdata[FP_W])
                    begin
                        ram_we      = 1'b1;
                        filled_next = filled_reg + 1'b1;
                    end
                    else if (check_reg && (ram_rdata[FP_W-1:0] != fp_reg)
                             && (conflicts_reg != '1))
                    begin
                        conf_after = conflicts_reg + 1'b1;
                    end
                end
                conflicts_next = conf_after;
                acc_next       = !in_range_reg || (conf_after == '0) || !check_reg;
                state_next     = S_EVAL;
            end
            S_EVAL:
            begin
                accepted_next       = acc_reg;
                all_received_next   = (filled_reg >= SLOT_CAP)
                                   || (cover_prod >= PROD_W'(total_reg));
                slots_filled_next   = FILLED_W'(filled_reg);
                conflict_count_next = conflicts_reg;
                state_next          = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = '0;
            if (clear_addr_reg == LAST_SLOT)
            begin
                clear_active_next = 1'b0;
            end
            else
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
            end
        end

        if (cfg_we)
        begin
            total_next        = cfg_wdata;
            filled_next       = '0;
            conflicts_next    = '0;
            crc_next          = CRC_INIT;
            bytes_seen_next   = '0;
            clear_active_next = 1'b1;
            clear_addr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            total_reg          <= '0;
            clear_active_reg   <= 1'b1;
            clear_addr_reg     <= '0;
            crc_reg            <= CRC_INIT;
            bytes_seen_reg     <= '0;
            offset_reg         <= '0;
            dq_reg             <= '0;
            rem_reg            <= '0;
            div_cnt_reg        <= '0;
            check_reg          <= 1'b0;
            in_range_reg       <= 1'b0;
            fp_reg             <= '0;
            filled_reg         <= '0;
            conflicts_reg      <= '0;
            acc_reg            <= 1'b0;
            accepted_reg       <= 1'b0;
            all_received_reg   <= 1'b0;
            slots_filled_reg   <= '0;
            conflict_count_reg <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            total_reg          <= total_next;
            clear_active_reg   <= clear_active_next;
            clear_addr_reg     <= clear_addr_next;
            crc_reg            <= crc_next;
            bytes_seen_reg     <= bytes_seen_next;
            offset_reg         <= offset_next;
            dq_reg             <= dq_next;
            rem_reg            <= rem_next;
            div_cnt_reg        <= div_cnt_next;
            check_reg          <= check_next;
            in_range_reg       <= in_range_next;
            fp_reg             <= fp_next;
            filled_reg         <= filled_next;
            conflicts_reg      <= conflicts_next;
            acc_reg            <= acc_next;
            accepted_reg       <= accepted_next;
            all_received_reg   <= all_received_next;
            slots_filled_reg   <= slots_filled_next;
            conflict_count_reg <= conflict_count_next;
        end
    end

    cct_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_SLOTS),
        .ADDR_W(SLOT_W)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    `CCT_ASSERT_ALWAYS(a_filled_bound, filled_reg <= SLOT_CAP, "filled count above slot capacity")
    `CCT_ASSERT_ALWAYS(a_bytes_bound, bytes_seen_reg <= CHUNK_LEN, "byte count past chunk size")
    `CCT_ASSERT_ALWAYS(a_read_after_div, (state_reg != S_READ) || (div_cnt_reg == DIV_STEPS),
        "slot read before division finished")
    `CCT_ASSERT_NEXT(a_conflicts_monotone, !cfg_we, conflicts_reg >= $past(conflicts_reg),
        "conflict count decreased without a size write")
    `CCT_ASSERT_NEXT(a_filled_step, !cfg_we,
        (filled_reg == $past(filled_reg)) || (filled_reg == $past(filled_reg) + 1'b1),
        "filled count jumped")

endmodule
